@@ sv/assert_macros.svh @@
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define IPT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("ipt assertion failed");

// Clocked assertion that is also checked during reset.
`define IPT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ipt assertion failed");

`endif

@@ sv/ipt_pkg.sv @@
// Package of the indexed priority task table: table size, codes and beat types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int AW = $clog2(TABLE_DEPTH);

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_EDIT   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_EXEC   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_DUP     = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] user_id;
        logic [15:0] task_id;
        logic [15:0] priority_req;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] owner_out;
        logic [15:0] task_out;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] user_id;
        logic [15:0] prio;
    } t_entry;

    typedef struct packed {
        logic          vld;
        logic [AW-1:0] idx;
        logic          used;
        t_entry        entry;
    } t_scan_step;

    typedef struct packed {
        logic          match_found;
        logic [AW-1:0] match_idx;
        logic [15:0]   match_user;
        logic          free_found;
        logic [AW-1:0] free_idx;
        logic          top_found;
        logic [AW-1:0] top_idx;
        logic [15:0]   top_user;
        logic [15:0]   top_task;
        logic [15:0]   top_prio;
    } t_scan_res;

endpackage

`default_nettype wire

@@ sv/ipt_scan.sv @@
// Scan accumulator: takes one table entry per beat and keeps the id match,
// the lowest free slot and the top entry. Depends on ipt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipt_scan (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_clear,
    input  wire logic [15:0]        i_task_id,
    input  wire ipt_pkg::t_scan_step i_step,
    output      ipt_pkg::t_scan_res  o_res
);
    import ipt_pkg::*;

    t_scan_res r_res;
    t_scan_res n_res;

    always_comb begin
        n_res = r_res;
        if (i_clear) begin
            n_res.match_found = 1'b0;
            n_res.free_found  = 1'b0;
            n_res.top_found   = 1'b0;
        end else if (i_step.vld) begin
            if (i_step.used && !r_res.match_found && i_step.entry.task_id == i_task_id) begin
                n_res.match_found = 1'b1;
                n_res.match_idx   = i_step.idx;
                n_res.match_user  = i_step.entry.user_id;
            end
            if (!i_step.used && !r_res.free_found) begin
                n_res.free_found = 1'b1;
                n_res.free_idx   = i_step.idx;
            end
            if (i_step.used && (!r_res.top_found ||
                {i_step.entry.prio, i_step.entry.task_id} >
                {r_res.top_prio, r_res.top_task})) begin
                n_res.top_found = 1'b1;
                n_res.top_idx   = i_step.idx;
                n_res.top_user  = i_step.entry.user_id;
                n_res.top_task  = i_step.entry.task_id;
                n_res.top_prio  = i_step.entry.prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.match_found <= 1'b0;
            r_res.free_found  <= 1'b0;
            r_res.top_found   <= 1'b0;
        end else begin
            r_res.match_found <= n_res.match_found;
            r_res.free_found  <= n_res.free_found;
            r_res.top_found   <= n_res.top_found;
        end
        r_res.match_idx  <= n_res.match_idx;
        r_res.match_user <= n_res.match_user;
        r_res.free_idx   <= n_res.free_idx;
        r_res.top_idx    <= n_res.top_idx;
        r_res.top_user   <= n_res.top_user;
        r_res.top_task   <= n_res.top_task;
        r_res.top_prio   <= n_res.top_prio;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

@@ sv/indexed_priority_task_table.sv @@
// Indexed priority task table, top level: entry memory, valid bits, sequencer
// and output register. Depends on ipt_pkg and ipt_scan.
//
// Usage: an input beat on i_in_beat carries one action (add, edit priority,
// remove, execute top) and is taken when i_in_valid is high and o_in_stall is
// low. Every beat produces exactly one result beat on o_out_beat, offered with
// o_out_valid and taken when i_out_stall is low.
// Each action reads every slot of the entry memory once through its single
// read port, then writes back. A new item is accepted only after the
// previous one has written back, as the sequencer returns to idle after
// each write-back. o_in_stall is high while an item is in work.
// A result waiting in the output register does not block the next item; if
// the receiver still stalls when the following result is ready, the block
// holds that result and keeps o_in_stall high until the register frees up.
// Reset clears all valid bits at once, so the table is empty and an item can
// be accepted in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module indexed_priority_task_table (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire ipt_pkg::t_in_beat  i_in_beat,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      ipt_pkg::t_out_beat o_out_beat
);
    import ipt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [AW:0]   DEPTH_C = (AW + 1)'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(TABLE_DEPTH - 1);

    t_entry mem [TABLE_DEPTH];
    t_entry r_rdata;

    logic [1:0]             r_state;
    logic [AW:0]            r_addr;
    logic                   r_rd_vld;
    logic [AW-1:0]          r_rd_idx;
    t_in_beat               r_req;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic                   r_out_valid;
    t_out_beat              r_out_beat;

    logic       w_accept;
    logic       w_done_fire;
    logic       w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry     w_wr_data;
    logic       w_set_en;
    logic       w_clr_en;
    logic [AW-1:0] w_set_idx;
    logic [AW-1:0] w_clr_idx;
    t_out_beat  n_out_beat;
    t_scan_step w_step;
    t_scan_res  w_res;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_done_fire = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign w_step.vld   = r_rd_vld;
    assign w_step.idx   = r_rd_idx;
    assign w_step.used  = r_valid[r_rd_idx];
    assign w_step.entry = r_rdata;

    ipt_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_accept),
        .i_task_id (r_req.task_id),
        .i_step    (w_step),
        .o_res     (w_res)
    );

    always_comb begin
        n_out_beat = '0;
        w_wr_en    = 1'b0;
        w_wr_addr  = w_res.free_idx;
        w_wr_data  = '{task_id: r_req.task_id, user_id: r_req.user_id,
                       prio: r_req.priority_req};
        w_set_en   = 1'b0;
        w_set_idx  = w_res.free_idx;
        w_clr_en   = 1'b0;
        w_clr_idx  = w_res.match_idx;
        unique case (r_req.action)
            ACT_ADD: begin
                if (w_res.match_found) begin
                    n_out_beat.status = ST_DUP;
                end else if (!w_res.free_found) begin
                    n_out_beat.status = ST_FULL;
                end else begin
                    w_wr_en  = 1'b1;
                    w_set_en = 1'b1;
                end
            end
            ACT_EDIT: begin
                if (!w_res.match_found) begin
                    n_out_beat.status = ST_MISSING;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_res.match_idx;
                    w_wr_data.user_id = w_res.match_user;
                end
            end
            ACT_REMOVE: begin
                if (!w_res.match_found) begin
                    n_out_beat.status = ST_MISSING;
                end else begin
                    w_clr_en = 1'b1;
                end
            end
            default: begin
                if (!w_res.top_found) begin
                    n_out_beat.status = ST_MISSING;
                end else begin
                    n_out_beat.owner_out = w_res.top_user;
                    n_out_beat.task_out  = w_res.top_task;
                    w_clr_en  = 1'b1;
                    w_clr_idx = w_res.top_idx;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_done_fire && w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr < DEPTH_C) begin
                        r_addr   <= r_addr + 1'b1;
                        r_rd_vld <= 1'b1;
                    end
                    if (r_rd_vld && r_rd_idx == LAST_C) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_done_fire) begin
                        r_state <= S_IDLE;
                        if (w_set_en) begin
                            r_valid[w_set_idx] <= 1'b1;
                        end
                        if (w_clr_en) begin
                            r_valid[w_clr_idx] <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_done_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[AW-1:0];
        if (w_accept) begin
            r_req <= i_in_beat;
        end
        if (w_done_fire) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

`default_nettype wire

@@ sv/ipt_checker.sv @@
// Port-level checker of the indexed priority task table and its bind.
// Depends on ipt_pkg, assert_macros.svh and indexed_priority_task_table.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ipt_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_stall,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_stall,
    input  wire ipt_pkg::t_out_beat o_out_beat
);
    import ipt_pkg::*;

    logic w_in_fire;
    logic w_out_held;
    logic w_fail_nonzero;

    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_out_held = o_out_valid && i_out_stall;
    assign w_fail_nonzero = o_out_valid && (o_out_beat.status != ST_OK) &&
                            (o_out_beat.owner_out != 16'd0 || o_out_beat.task_out != 16'd0);

    `IPT_ASSERT(a_out_valid_holds, i_clk, i_rst_n, w_out_held |=> o_out_valid)
    `IPT_ASSERT(a_out_beat_holds, i_clk, i_rst_n, w_out_held |=> $stable(o_out_beat))
    `IPT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, w_in_fire |=> o_in_stall)
    `IPT_ASSERT(a_fail_zero, i_clk, i_rst_n, !w_fail_nonzero)
    `IPT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall))

endmodule

bind indexed_priority_task_table ipt_checker u_ipt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire
